FILE: sv/p2cmp_pkg.sv
// Package: shared widths, entry type, op codes and the CORDIC arctangent table.
`default_nettype none
package p2cmp_pkg;

  // Iteration count and angle path width of the CORDIC
  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 16;

  // Guard bits kept below the Q16.16 point during rotation
  localparam int GUARD    = 16;
  localparam int ATAN_MAX = 24;
  localparam int ITERS    = (CORDIC_STEPS < ATAN_MAX) ? CORDIC_STEPS : ATAN_MAX;
  localparam int CNT_W    = $clog2(ITERS);

  // 1/K in Q30, floored down to GUARD fraction bits after the multiply
  localparam logic [30:0] INV_GAIN_Q30 = 31'd652032874;
  localparam int PRE_SHIFT = 30 - GUARD;
  localparam int PRE_W     = 32 + GUARD;

  // Rotation datapath: prescaled vector plus growth from the CORDIC gain
  localparam int VEC_W = PRE_W + 2;
  // Angle path: two bits over ANGLE_BITS for the residual
  localparam int ANG_W = ANGLE_BITS + 2;
  // Rounded delta and the widened position sum
  localparam int DEL_W = VEC_W - GUARD;
  localparam int SUM_W = DEL_W + 2;

  // Op codes
  localparam logic OP_STEP = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // One request as queued between front and back
  typedef struct packed {
    logic                    op;
    logic signed [PRE_W-1:0] a;     // prescaled step x, or load x
    logic signed [PRE_W-1:0] b;     // prescaled step y, or load y
    logic [15:0]             turn;  // turn, or load heading
  } entry_t;

  // arctan(2^-i) in turns, Q32, cut to ANGLE_BITS
  function automatic logic [ANGLE_BITS-1:0] atan_angle(input logic [4:0] idx);
    logic [31:0] t;
    case (idx)
      5'd0:    t = 32'd536870912;
      5'd1:    t = 32'd316933405;
      5'd2:    t = 32'd167458907;
      5'd3:    t = 32'd85004756;
      5'd4:    t = 32'd42667331;
      5'd5:    t = 32'd21354465;
      5'd6:    t = 32'd10679838;
      5'd7:    t = 32'd5340245;
      5'd8:    t = 32'd2670163;
      5'd9:    t = 32'd1335087;
      5'd10:   t = 32'd667544;
      5'd11:   t = 32'd333772;
      5'd12:   t = 32'd166886;
      5'd13:   t = 32'd83443;
      5'd14:   t = 32'd41721;
      5'd15:   t = 32'd20860;
      5'd16:   t = 32'd10430;
      5'd17:   t = 32'd5215;
      5'd18:   t = 32'd2607;
      5'd19:   t = 32'd1303;
      5'd20:   t = 32'd651;
      5'd21:   t = 32'd325;
      5'd22:   t = 32'd162;
      5'd23:   t = 32'd81;
      default: t = 32'd0;
    endcase
    return t[31 -: ANGLE_BITS];
  endfunction

endpackage
`default_nettype wire

FILE: sv/p2cmp_front.sv
// Front end: takes requests, classifies them and prescales step vectors by 1/K.
`default_nettype none
module p2cmp_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                cmd,
  input  wire logic signed [31:0]  step_x,
  input  wire logic signed [31:0]  step_y,
  input  wire logic signed [15:0]  step_turn,
  output logic                     push,
  input  wire logic                full,
  output p2cmp_pkg::entry_t        push_entry
);

  logic               fvalid;
  logic               fop;
  logic signed [31:0] fsx;
  logic signed [31:0] fsy;
  logic [15:0]        fturn;

  logic signed [62:0] prod_x;
  logic signed [62:0] prod_y;

  assign push     = fvalid && !full;
  assign in_ready = !fvalid || push;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (in_ready) begin
      fvalid <= in_valid;
    end
    if (in_ready && in_valid) begin
      fop   <= cmd ? p2cmp_pkg::OP_LOAD : p2cmp_pkg::OP_STEP;
      fsx   <= step_x;
      fsy   <= step_y;
      fturn <= step_turn;
    end
  end

  // Prescale by the inverse CORDIC gain, floored to guard bits
  always_comb begin
    prod_x = fsx * $signed({1'b0, p2cmp_pkg::INV_GAIN_Q30});
    prod_y = fsy * $signed({1'b0, p2cmp_pkg::INV_GAIN_Q30});
    push_entry.op   = fop;
    push_entry.turn = fturn;
    if (fop == p2cmp_pkg::OP_LOAD) begin
      push_entry.a = p2cmp_pkg::PRE_W'(fsx);
      push_entry.b = p2cmp_pkg::PRE_W'(fsy);
    end else begin
      push_entry.a = prod_x[p2cmp_pkg::PRE_SHIFT + p2cmp_pkg::PRE_W - 1 : p2cmp_pkg::PRE_SHIFT];
      push_entry.b = prod_y[p2cmp_pkg::PRE_SHIFT + p2cmp_pkg::PRE_W - 1 : p2cmp_pkg::PRE_SHIFT];
    end
  end

endmodule
`default_nettype wire

FILE: sv/p2cmp_queue.sv
// Two-entry request queue between front and back.
`default_nettype none
module p2cmp_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire p2cmp_pkg::entry_t push_entry,
  output logic                   full,
  input  wire logic              pop,
  output logic                   empty,
  output p2cmp_pkg::entry_t      pop_entry
);

  p2cmp_pkg::entry_t mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign full      = (count == 2'd2);
  assign empty     = (count == 2'd0);
  assign pop_entry = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: sv/p2cmp_back.sv
// Back end: pose state, iterative CORDIC rotation, saturating update, output register.
`default_nettype none
module p2cmp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              empty,
  input  wire p2cmp_pkg::entry_t pop_entry,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [31:0]     out_x,
  output logic signed [31:0]     out_y,
  output logic signed [15:0]     out_heading,
  output logic                   saturated
);

  localparam int XW = p2cmp_pkg::VEC_W;
  localparam int ZW = p2cmp_pkg::ANG_W;
  localparam int AB = p2cmp_pkg::ANGLE_BITS;
  localparam int SW = p2cmp_pkg::SUM_W;
  localparam int DW = p2cmp_pkg::DEL_W;
  localparam int CW = p2cmp_pkg::CNT_W;
  localparam int SHL = (AB >= 16) ? AB - 16 : 0;
  localparam int SHR = (AB < 16) ? 16 - AB : 0;

  localparam logic signed [ZW-1:0] QUARTER = ZW'(1) << (AB - 2);
  localparam logic signed [ZW-1:0] HALF    = ZW'(1) << (AB - 1);
  localparam logic signed [XW-1:0] RND     = XW'(1) << (p2cmp_pkg::GUARD - 1);
  localparam logic signed [SW-1:0] POS_MAX = SW'(32'sh7FFFFFFF);
  localparam logic signed [SW-1:0] NEG_MIN = -POS_MAX - SW'(1);
  localparam logic [CW-1:0]        CNT_LAST = CW'(p2cmp_pkg::ITERS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROT  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]               state;
  logic [1:0]               state_next;

  // Pose
  logic signed [31:0]       pose_x;
  logic signed [31:0]       pose_y;
  logic [15:0]              heading;

  // Request in flight
  logic                     op;
  logic [15:0]              turn;
  logic signed [31:0]       load_x;
  logic signed [31:0]       load_y;
  logic signed [XW-1:0]     x;
  logic signed [XW-1:0]     y;
  logic signed [ZW-1:0]     z;
  logic [CW-1:0]            cnt;

  logic signed [25:0]       h_ext;
  logic signed [25:0]       h_scaled;
  logic signed [ZW-1:0]     z_in;
  logic signed [ZW-1:0]     z0;
  logic                     flip;
  logic signed [XW-1:0]     xa;
  logic signed [XW-1:0]     yb;
  logic signed [XW-1:0]     xs;
  logic signed [XW-1:0]     ys;
  logic signed [ZW-1:0]     a_step;
  logic signed [XW-1:0]     x_rnd;
  logic signed [XW-1:0]     y_rnd;
  logic signed [DW-1:0]     dx;
  logic signed [DW-1:0]     dy;
  logic signed [SW-1:0]     sum_x;
  logic signed [SW-1:0]     sum_y;
  logic signed [31:0]       new_x;
  logic signed [31:0]       new_y;
  logic                     sat_x;
  logic                     sat_y;
  logic                     out_free;
  logic                     finish;

  assign out_free = !out_valid || out_ready;
  assign pop      = (state == S_IDLE) && !empty;
  assign finish   = (state == S_DONE) && out_free;

  // Heading to angle path, then fold into the right half plane
  always_comb begin
    h_ext    = 26'(signed'(heading));
    h_scaled = (h_ext <<< SHL) >>> SHR;
    z_in     = h_scaled[ZW-1:0];
    xa       = XW'(pop_entry.a);
    yb       = XW'(pop_entry.b);
    flip     = (z_in > QUARTER) || (z_in < -QUARTER);
    if (z_in > QUARTER) begin
      z0 = z_in - HALF;
    end else if (z_in < -QUARTER) begin
      z0 = z_in + HALF;
    end else begin
      z0 = z_in;
    end
  end

  // One CORDIC micro-rotation
  always_comb begin
    xs     = x >>> cnt;
    ys     = y >>> cnt;
    a_step = ZW'(p2cmp_pkg::atan_angle(5'(cnt)));
  end

  // Round back to Q16.16 and add with clipping
  always_comb begin
    x_rnd = x + RND;
    y_rnd = y + RND;
    dx    = x_rnd[XW-1:p2cmp_pkg::GUARD];
    dy    = y_rnd[XW-1:p2cmp_pkg::GUARD];
    sum_x = SW'(pose_x) + SW'(dx);
    sum_y = SW'(pose_y) + SW'(dy);
    sat_x = (sum_x > POS_MAX) || (sum_x < NEG_MIN);
    sat_y = (sum_y > POS_MAX) || (sum_y < NEG_MIN);
    if (sum_x > POS_MAX)      new_x = 32'sh7FFFFFFF;
    else if (sum_x < NEG_MIN) new_x = 32'sh80000000;
    else                      new_x = sum_x[31:0];
    if (sum_y > POS_MAX)      new_y = 32'sh7FFFFFFF;
    else if (sum_y < NEG_MIN) new_y = 32'sh80000000;
    else                      new_y = sum_y[31:0];
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!empty) begin
          state_next = (pop_entry.op == p2cmp_pkg::OP_LOAD) ? S_DONE : S_ROT;
        end
      end
      S_ROT: begin
        if (cnt == CNT_LAST) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      op     <= pop_entry.op;
      turn   <= pop_entry.turn;
      load_x <= pop_entry.a[31:0];
      load_y <= pop_entry.b[31:0];
      x      <= flip ? -xa : xa;
      y      <= flip ? -yb : yb;
      z      <= z0;
      cnt    <= '0;
    end else if (state == S_ROT) begin
      if (!z[ZW-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - a_step;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + a_step;
      end
      cnt <= cnt + CW'(1);
    end
  end

  // Pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x  <= '0;
      pose_y  <= '0;
      heading <= '0;
    end else if (finish) begin
      if (op == p2cmp_pkg::OP_LOAD) begin
        pose_x  <= load_x;
        pose_y  <= load_y;
        heading <= turn;
      end else begin
        pose_x  <= new_x;
        pose_y  <= new_y;
        heading <= heading + turn;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (finish) begin
      if (op == p2cmp_pkg::OP_LOAD) begin
        out_x       <= load_x;
        out_y       <= load_y;
        out_heading <= turn;
        saturated   <= 1'b0;
      end else begin
        out_x       <= new_x;
        out_y       <= new_y;
        out_heading <= heading + turn;
        saturated   <= sat_x || sat_y;
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == S_ROT || state == S_DONE))
    else $error("queue popped outside idle");
  a_load_nosat: assert property (@(posedge clk) disable iff (rst)
    (finish && op == p2cmp_pkg::OP_LOAD) |=> (out_valid && !saturated))
    else $error("load request flagged saturation");
  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    finish |=> (out_valid && state == S_IDLE))
    else $error("finished request did not reach output register");
  a_rot_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROT && cnt != CNT_LAST) |=> state == S_ROT)
    else $error("rotation ended early");
`endif

endmodule
`default_nettype wire

FILE: sv/pose2d_compose_accumulate_core.sv
// Top level: planar pose accumulator, front end, request queue and CORDIC back end.
// Usage:
//   Input channel (in_valid/in_ready) carries one request: cmd 0 composes a
//   step (step_x forward, step_y sideways, Q16.16; step_turn binary angle)
//   onto the held pose, cmd 1 loads the pose from the same fields.
//   Output channel (out_valid/out_ready) returns the updated pose for every
//   request: out_x, out_y (Q16.16, clipped), out_heading (wraps), and
//   saturated when x or y was clipped on that request.
//   The back end works on one request at a time: a compose takes a setup
//   step, 16 CORDIC iterations on one shared shift-add unit and an update
//   step that waits for a free output register, a load setup and update
//   only; it pops the next request after the update, so that loop sets the rate.
//   The front register and a two-entry queue keep taking requests while the
//   back end works or a result waits in the output register; when the
//   receiver holds out_ready low the result stays put and in_ready drops
//   once queue and front register are full.
//   Reset (rst, synchronous) clears the pose to zero and empties the queue.
`default_nettype none
module pose2d_compose_accumulate_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               cmd,
  input  wire logic signed [31:0] step_x,
  input  wire logic signed [31:0] step_y,
  input  wire logic signed [15:0] step_turn,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [15:0]      out_heading,
  output logic                    saturated
);

  logic              push;
  logic              full;
  logic              pop;
  logic              empty;
  p2cmp_pkg::entry_t push_entry;
  p2cmp_pkg::entry_t pop_entry;

  p2cmp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .step_x     (step_x),
    .step_y     (step_y),
    .step_turn  (step_turn),
    .push       (push),
    .full       (full),
    .push_entry (push_entry)
  );

  p2cmp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .pop_entry  (pop_entry)
  );

  p2cmp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (empty),
    .pop_entry   (pop_entry),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_heading (out_heading),
    .saturated   (saturated)
  );

endmodule
`default_nettype wire

FILE: tb/pose2d_compose_accumulate_core_tb.sv
// Testbench for the planar pose accumulator: directed table, random requests, reference predictor.
`timescale 1ns / 1ps
`default_nettype none
module pose2d_compose_accumulate_core_tb;

  localparam int  CYCLE_LIMIT   = 400000;
  localparam int  PHASE_ITEMS   = 488;
  localparam int  HOLD_CYCLES   = 300;
  localparam int  DRAIN_CYCLES  = 40;
  localparam int  MAX_PRINTS    = 100;
  localparam int  GUARD_BITS    = 16;
  localparam longint INV_GAIN   = 64'sd652032874;
  localparam int  ATAN_COUNT    = 24;

  // arctan(2^-i) as a fraction of one turn, Q32
  localparam longint ATAN_TURN [ATAN_COUNT] = '{
    536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41721, 20860, 10430, 5215,
    2607, 1303, 651, 325, 162, 81
  };

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] heading;
    logic               sat;
  } pose_t;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic [15:0]        turn;
    logic               typed;
    pose_t              want;
  } req_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               cmd;
  logic signed [31:0] step_x;
  logic signed [31:0] step_y;
  logic signed [15:0] step_turn;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [15:0] out_heading;
  logic               saturated;

  // predictor copy of the pose
  longint      track_x;
  longint      track_y;
  logic [15:0] track_heading;

  pose_t pending_poses[$];
  int    mismatches = 0;
  int    cycles     = 0;
  int    send_idle_pct = 0;
  int    stall_pct     = 0;
  int    hold_seq = 0;
  int    seen_seq = 0;
  int    hold_cnt = 0;

  // directed requests; typed poses where the answer is obvious
  req_row_t dir_rows [20] = '{
    '{p2cmp_pkg::OP_STEP, 32'sh0, 32'sh0, 16'h0000, 1'b1,
      '{32'sh0, 32'sh0, 16'sh0000, 1'b0}},
    '{p2cmp_pkg::OP_STEP, 32'sh0, 32'sh0, 16'd100, 1'b1,
      '{32'sh0, 32'sh0, 16'sd100, 1'b0}},
    '{p2cmp_pkg::OP_LOAD, 32'sh7FFFFFFF, 32'sh80000000, 16'h8000, 1'b1,
      '{32'sh7FFFFFFF, 32'sh80000000, 16'sh8000, 1'b0}},
    '{p2cmp_pkg::OP_LOAD, 32'sh0, 32'sh0, 16'h7FFF, 1'b1,
      '{32'sh0, 32'sh0, 16'sh7FFF, 1'b0}},
    // heading wraps past the positive limit
    '{p2cmp_pkg::OP_STEP, 32'sh0, 32'sh0, 16'h0001, 1'b1,
      '{32'sh0, 32'sh0, 16'sh8000, 1'b0}},
    // half turn heading
    '{p2cmp_pkg::OP_STEP, 32'sh00010000, 32'sh0, 16'h0000, 1'b0, '0},
    '{p2cmp_pkg::OP_LOAD, 32'sh7FFFFFF0, 32'sh0, 16'h0000, 1'b1,
      '{32'sh7FFFFFF0, 32'sh0, 16'sh0000, 1'b0}},
    // positive clip
    '{p2cmp_pkg::OP_STEP, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'h0000, 1'b0, '0},
    '{p2cmp_pkg::OP_LOAD, 32'sh80000010, 32'sh80000010, 16'h4000, 1'b1,
      '{32'sh80000010, 32'sh80000010, 16'sh4000, 1'b0}},
    // exactly a quarter turn
    '{p2cmp_pkg::OP_STEP, 32'sh7FFFFFFF, 32'sh80000000, 16'h0000, 1'b0, '0},
    '{p2cmp_pkg::OP_LOAD, 32'sh0, 32'sh0, 16'hC000, 1'b1,
      '{32'sh0, 32'sh0, 16'shC000, 1'b0}},
    // exactly minus a quarter turn
    '{p2cmp_pkg::OP_STEP, 32'sh80000000, 32'sh7FFFFFFF, 16'h4001, 1'b0, '0},
    '{p2cmp_pkg::OP_STEP, 32'sh00010000, 32'sh00010000, 16'h4000, 1'b0, '0},
    // just beyond a quarter turn
    '{p2cmp_pkg::OP_STEP, 32'sh00010000, 32'sh00010000, 16'h0000, 1'b0, '0},
    '{p2cmp_pkg::OP_STEP, 32'shFFFFFFFF, 32'sh00000001, 16'hFFFF, 1'b0, '0},
    '{p2cmp_pkg::OP_STEP, 32'sh12345678, 32'shEDCBA987, 16'h8000, 1'b0, '0},
    '{p2cmp_pkg::OP_LOAD, 32'shFFFFFFFF, 32'shFFFFFFFF, 16'hFFFF, 1'b1,
      '{32'shFFFFFFFF, 32'shFFFFFFFF, 16'shFFFF, 1'b0}},
    // negative clip
    '{p2cmp_pkg::OP_STEP, 32'sh80000000, 32'sh80000000, 16'h8000, 1'b0, '0},
    '{p2cmp_pkg::OP_STEP, 32'sh80000000, 32'sh80000000, 16'h0000, 1'b0, '0},
    '{p2cmp_pkg::OP_LOAD, 32'sh0, 32'sh0, 16'h0000, 1'b1,
      '{32'sh0, 32'sh0, 16'sh0000, 1'b0}}
  };

  pose2d_compose_accumulate_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .step_x     (step_x),
    .step_y     (step_y),
    .step_turn  (step_turn),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_heading(out_heading),
    .saturated  (saturated)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // rotate a step by the tracked heading through the CORDIC
  function automatic void rotate_by_heading(input longint sx, input longint sy,
                                            output longint dx, output longint dy);
    longint half, quarter, h, z, x, y, a, xs, ys;
    int     sh;
    half    = 64'sd1 <<< (p2cmp_pkg::ANGLE_BITS - 1);
    quarter = 64'sd1 <<< (p2cmp_pkg::ANGLE_BITS - 2);
    h       = $signed(track_heading);
    sh      = (p2cmp_pkg::ANGLE_BITS >= 16) ? p2cmp_pkg::ANGLE_BITS - 16
                                            : 16 - p2cmp_pkg::ANGLE_BITS;
    if (p2cmp_pkg::ANGLE_BITS >= 16) begin
      z = h <<< sh;
    end else begin
      z = ((h + 32768) >>> sh) - (64'sd32768 >>> sh);
    end
    x = (sx * INV_GAIN) >>> (30 - GUARD_BITS);
    y = (sy * INV_GAIN) >>> (30 - GUARD_BITS);
    // fold headings past a quarter turn back by a half turn
    if (z > quarter) begin
      z = z - half;
      x = -x;
      y = -y;
    end else if (z < -quarter) begin
      z = z + half;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < p2cmp_pkg::CORDIC_STEPS && i < ATAN_COUNT; i++) begin
      a  = ATAN_TURN[i] >> (32 - p2cmp_pkg::ANGLE_BITS);
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - a;
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + a;
      end
    end
    dx = (x + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
    dy = (y + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
  endfunction

  function automatic longint clip_position(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // advance the tracked pose by one request and return the new pose
  function automatic pose_t advance_pose(input logic c, input logic signed [31:0] sx,
                                         input logic signed [31:0] sy,
                                         input logic [15:0] turn);
    longint dx, dy;
    logic   sat;
    pose_t  p;
    sat = 1'b0;
    if (c == p2cmp_pkg::OP_LOAD) begin
      track_x       = sx;
      track_y       = sy;
      track_heading = turn;
    end else begin
      rotate_by_heading(sx, sy, dx, dy);
      track_x       = clip_position(track_x + dx, sat);
      track_y       = clip_position(track_y + dy, sat);
      track_heading = track_heading + turn;
    end
    p.x       = track_x[31:0];
    p.y       = track_y[31:0];
    p.heading = track_heading;
    p.sat     = sat;
    return p;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    if (mismatches < MAX_PRINTS) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // offer one request; starts and ends at a falling edge
  task automatic send_request(input logic c, input logic signed [31:0] sx,
                              input logic signed [31:0] sy, input logic [15:0] turn,
                              input logic typed, input pose_t typed_pose);
    pose_t p;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    step_x    <= sx;
    step_y    <= sy;
    step_turn <= turn;
    do @(posedge clk); while (!in_ready);
    p = advance_pose(c, sx, sy, turn);
    pending_poses.push_back(typed ? typed_pose : p);
    @(negedge clk);
  endtask

  // random request: mostly realistic steps, some loads and full-range values
  task automatic pick_request(output logic c, output logic signed [31:0] sx,
                              output logic signed [31:0] sy, output logic [15:0] turn);
    int r, k;
    r  = $urandom_range(0, 99);
    c  = (r < 8) ? p2cmp_pkg::OP_LOAD : p2cmp_pkg::OP_STEP;
    if (r < 4 || (r >= 8 && r < 18)) begin
      sx = $urandom;
      sy = $urandom;
    end else begin
      sx = int'($urandom_range(0, 1 << 27)) - (1 << 26);
      sy = int'($urandom_range(0, 1 << 27)) - (1 << 26);
      if (c == p2cmp_pkg::OP_STEP) begin
        sx = sx >>> 6;
        sy = sy >>> 6;
      end
    end
    k = $urandom_range(0, 99);
    if (k < 40) begin
      turn = 16'($urandom);
    end else if (k < 90) begin
      turn = 16'(int'($urandom_range(0, 4096)) - 2048);
    end else begin
      case ($urandom_range(0, 3))
        0:       turn = 16'h4000;
        1:       turn = 16'hC000;
        2:       turn = 16'h8000;
        default: turn = 16'h0000;
      endcase
    end
  endtask

  // receiver: random stalls plus a long hold-off when a phase asks for one
  always @(negedge clk) begin
    if (hold_seq != seen_seq) begin
      seen_seq = hold_seq;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // compare each returned pose with the oldest pending one
  always @(posedge clk) begin
    pose_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_poses.size() == 0) begin
        flag_mismatch("result with no request pending", out_x, 0);
      end else begin
        want = pending_poses.pop_front();
        if (out_x !== want.x) flag_mismatch("out_x", out_x, want.x);
        if (out_y !== want.y) flag_mismatch("out_y", out_y, want.y);
        if (out_heading !== want.heading) flag_mismatch("out_heading", out_heading, want.heading);
        if (saturated !== want.sat) flag_mismatch("saturated", saturated, want.sat);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int           idle_tab [4];
    int           stall_tab[4];
    logic         c;
    logic signed [31:0] sx, sy;
    logic [15:0]  turn;
    idle_tab  = '{0, 68, 0, 36};
    stall_tab = '{0, 0, 68, 36};
    rst       = 1'b1;
    in_valid  = 1'b0;
    cmd       = p2cmp_pkg::OP_STEP;
    step_x    = '0;
    step_y    = '0;
    step_turn = '0;
    track_x       = 0;
    track_y       = 0;
    track_heading = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].cmd, dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].turn,
                   dir_rows[i].typed, dir_rows[i].want);
    end

    // random phases; the first one also holds the receiver off for a while
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tab[ph];
      stall_pct     = stall_tab[ph];
      if (ph == 0) hold_seq++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick_request(c, sx, sy, turn);
        send_request(c, sx, sy, turn, 1'b0, '0);
      end
    end
    in_valid  <= 1'b0;
    stall_pct = 0;

    while (pending_poses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
sv/p2cmp_pkg.sv
sv/p2cmp_front.sv
sv/p2cmp_queue.sv
sv/p2cmp_back.sv
sv/pose2d_compose_accumulate_core.sv
tb/pose2d_compose_accumulate_core_tb.sv
